@@ src/nff_pkg.sv @@
// Shared types, character codes and helper functions of the number field formatter.
package nff_pkg;

    localparam int FUNC_BITS  = 2;
    localparam int WIDTH_BITS = 7;
    localparam int CHAR_BITS  = 8;

    localparam logic [FUNC_BITS-1:0] FUNC_DEC  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_HEX  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CHR  = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_NONE = 2'd3;

    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;

    typedef struct packed {
        logic load_dec;
        logic load_hex;
        logic dabble;
        logic shift;
    } t_dig_cmd;

    function automatic int num_digits(input int value_bits);
        int n_dec;
        int n_hex;
        n_dec = (value_bits * 30103) / 100000 + 1;
        n_hex = (value_bits + 3) / 4;
        return (n_dec > n_hex) ? n_dec : n_hex;
    endfunction

    function automatic logic [CHAR_BITS-1:0] hex_char(input logic [3:0] digit);
        logic [CHAR_BITS-1:0] res;
        if (digit < 4'd10) begin
            res = CH_ZERO + {4'h0, digit};
        end else begin
            res = CH_UPPER_A + {4'h0, digit - 4'd10};
        end
        return res;
    endfunction

endpackage

@@ src/nff_digits.sv @@
// Digit shift register: bit-serial binary to BCD conversion, hex load and digit shift-out.
module nff_digits #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  i_clk,
    input  nff_pkg::t_dig_cmd     i_cmd,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic [3:0]            o_top_digit
);

    localparam int NDIG  = nff_pkg::num_digits(VALUE_BITS);
    localparam int DIG_W = NDIG * 4;

    logic [VALUE_BITS-1:0] r_bin;
    logic [DIG_W-1:0]      r_dig;
    logic [DIG_W-1:0]      w_adj;
    logic [VALUE_BITS-1:0] w_mag;

    assign w_mag = i_value[VALUE_BITS-1] ? (~i_value + VALUE_BITS'(1)) : i_value;

    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            w_adj[k*4 +: 4] = (r_dig[k*4 +: 4] >= 4'd5) ? (r_dig[k*4 +: 4] + 4'd3)
                                                         : r_dig[k*4 +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.load_dec) begin
            r_bin <= w_mag;
            r_dig <= '0;
        end else if (i_cmd.load_hex) begin
            r_dig <= DIG_W'(i_value);
        end else if (i_cmd.dabble) begin
            r_dig <= {w_adj[DIG_W-2:0], r_bin[VALUE_BITS-1]};
            r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
        end else if (i_cmd.shift) begin
            r_dig <= {r_dig[DIG_W-5:0], 4'h0};
        end else begin
            r_bin <= r_bin;
            r_dig <= r_dig;
        end
    end

    assign o_top_digit = r_dig[DIG_W-1 -: 4];

endmodule

@@ src/nff_seq.sv @@
// Sequencer: conversion control, leading-zero strip, padding and the output word register.
module nff_seq #(
    parameter int MAX_WIDTH  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [nff_pkg::FUNC_BITS-1:0]       i_func,
    input  logic                                i_sign,
    input  logic [nff_pkg::CHAR_BITS-1:0]       i_byte,
    input  logic [nff_pkg::WIDTH_BITS-1:0]      i_width,
    input  logic                                i_pad_zero,
    input  logic [3:0]                          i_top_digit,
    output nff_pkg::t_dig_cmd                   o_cmd,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [nff_pkg::CHAR_BITS-1:0]       o_char_code,
    output logic                                o_last
);

    localparam int NDIG   = nff_pkg::num_digits(VALUE_BITS);
    localparam int NDIG_W = $clog2(NDIG + 1);
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int WB     = nff_pkg::WIDTH_BITS;
    localparam int CB     = nff_pkg::CHAR_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_NORM,
        S_PAD,
        S_SIGN,
        S_DIG,
        S_CHR
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [NDIG_W-1:0] r_ndig;
    logic [WB-1:0]     r_width;
    logic [WB-1:0]     r_pad;
    logic [CB-1:0]     r_pad_char;
    logic [CB-1:0]     r_byte;
    logic              r_neg;
    logic              r_is_chr;
    logic              r_out_valid;
    logic [CB-1:0]     r_char_code;
    logic              r_last;

    logic [WB-1:0]     w_sat;
    logic [WB-1:0]     w_len;
    logic              w_can;
    logic              w_take;
    logic              w_strip;
    logic              w_accept;

    assign w_sat    = (i_width > WB'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : i_width;
    assign w_len    = WB'(r_ndig) + WB'(r_neg);
    assign w_can    = !r_out_valid || i_out_ready;
    assign w_strip  = (r_state == S_NORM) && (i_top_digit == 4'h0) && (r_ndig > NDIG_W'(1));
    assign w_accept = (r_state == S_IDLE) && i_in_valid;
    assign w_take   = w_can && (((r_state == S_PAD) && (r_pad != '0)) || (r_state == S_SIGN)
                                || (r_state == S_DIG) || (r_state == S_CHR));

    always_comb begin
        o_cmd.load_dec = w_accept && (i_func == nff_pkg::FUNC_DEC);
        o_cmd.load_hex = w_accept && (i_func == nff_pkg::FUNC_HEX);
        o_cmd.dabble   = (r_state == S_CONV);
        o_cmd.shift    = w_strip || ((r_state == S_DIG) && w_can);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_width    <= w_sat;
                        r_pad_char <= i_pad_zero ? nff_pkg::CH_ZERO : nff_pkg::CH_SPACE;
                        r_byte     <= i_byte;
                        r_neg      <= (i_func == nff_pkg::FUNC_DEC) && i_sign;
                        r_is_chr   <= (i_func == nff_pkg::FUNC_CHR);
                        unique case (i_func)
                            nff_pkg::FUNC_DEC: begin
                                r_cnt   <= CNT_W'(VALUE_BITS);
                                r_state <= S_CONV;
                            end
                            nff_pkg::FUNC_HEX: begin
                                r_ndig  <= NDIG_W'(NDIG);
                                r_state <= S_NORM;
                            end
                            nff_pkg::FUNC_CHR: begin
                                r_pad   <= (w_sat > WB'(1)) ? (w_sat - WB'(1)) : '0;
                                r_state <= S_PAD;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CONV: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_ndig  <= NDIG_W'(NDIG);
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (w_strip) begin
                        r_ndig <= r_ndig - NDIG_W'(1);
                    end else begin
                        r_pad   <= (r_width > w_len) ? (r_width - w_len) : '0;
                        r_state <= S_PAD;
                    end
                end
                S_PAD: begin
                    if (r_pad == '0) begin
                        r_state <= r_is_chr ? S_CHR : (r_neg ? S_SIGN : S_DIG);
                    end else if (w_take) begin
                        r_pad       <= r_pad - WB'(1);
                        r_char_code <= r_pad_char;
                        r_last      <= 1'b0;
                    end
                end
                S_SIGN: begin
                    if (w_take) begin
                        r_char_code <= nff_pkg::CH_MINUS;
                        r_last      <= 1'b0;
                        r_state     <= S_DIG;
                    end
                end
                S_DIG: begin
                    if (w_take) begin
                        r_char_code <= nff_pkg::hex_char(i_top_digit);
                        r_last      <= (r_ndig == NDIG_W'(1));
                        r_ndig      <= r_ndig - NDIG_W'(1);
                        if (r_ndig == NDIG_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_CHR: begin
                    if (w_take) begin
                        r_char_code <= r_byte;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_char_code = r_char_code;
    assign o_last      = r_last;

endmodule

@@ src/number_field_formatter_unit.sv @@
// Top level of the number field formatter: digit register plus sequencer.
// After the accept cycle, decimal words run a bit-serial conversion over VALUE_BITS bits, strip up to
// D-1 leading zeros (D = digit register length, 10 at 32 bits), then emit pad, sign and digit
// characters; hex words skip the conversion; char words emit the pad characters and then the byte.
// Reset clears the sequencer and the output valid flag; no clearing pass is needed.
module number_field_formatter_unit #(
    parameter int MAX_WIDTH  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [nff_pkg::FUNC_BITS-1:0]         i_func,
    input  logic signed [VALUE_BITS-1:0]          i_value,
    input  logic [nff_pkg::WIDTH_BITS-1:0]        i_width,
    input  logic                                  i_pad_zero,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [nff_pkg::CHAR_BITS-1:0]         o_char_code,
    output logic                                  o_last
);

    nff_pkg::t_dig_cmd w_cmd;
    logic [3:0]        w_top_digit;

    nff_digits #(
        .VALUE_BITS(VALUE_BITS)
    ) u_digits (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_value    (i_value),
        .o_top_digit(w_top_digit)
    );

    nff_seq #(
        .MAX_WIDTH (MAX_WIDTH),
        .VALUE_BITS(VALUE_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_func     (i_func),
        .i_sign     (i_value[VALUE_BITS-1]),
        .i_byte     (i_value[7:0]),
        .i_width    (i_width),
        .i_pad_zero (i_pad_zero),
        .i_top_digit(w_top_digit),
        .o_cmd      (w_cmd),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_char_code(o_char_code),
        .o_last     (o_last)
    );

endmodule

@@ src/nff_checker.sv @@
// Port-level checker for the number field formatter and its bind statement.
module nff_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic [nff_pkg::FUNC_BITS-1:0]   i_func,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [nff_pkg::CHAR_BITS-1:0]   o_char_code,
    input logic                            o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_char_code) && $stable(o_last))
        else $error("Output word changed while stalled.");

    a_ignored_func: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_func == nff_pkg::FUNC_NONE) |=> o_in_ready)
        else $error("Unused mode did not leave the block idle.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_func != nff_pkg::FUNC_NONE) |=> !o_in_ready)
        else $error("Block stayed ready after taking a conversion word.");

    a_no_output_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && $past(o_in_ready) && !$past(o_out_valid) |-> !o_out_valid)
        else $error("Output word appeared while idle.");

endmodule

bind number_field_formatter_unit nff_checker u_nff_checker (.*);

@@ dv/number_field_formatter_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the number field formatter: a directed table, then random words.
module number_field_formatter_unit_tb;

    localparam int MAX_W        = 64;
    localparam int RANDOM_WORDS = 130;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 150;
    localparam int N_DIR        = 24;
    localparam logic [127:0] HEX_GLYPHS = "0123456789ABCDEF";

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_field_char;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] value;
        logic [6:0]  width;
        logic        pad_zero;
        logic [3:0]  golden_len;
        logic [95:0] golden;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_func = nff_pkg::FUNC_DEC;
    logic signed [31:0] i_value = '0;
    logic [6:0]  i_width = '0;
    logic        i_pad_zero = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_char_code;
    logic        o_last;

    t_field_char pending_chars[$];
    int n_errors = 0;
    int n_chars = 0;
    int n_dec = 0;
    int n_hex = 0;
    int n_chr = 0;
    int n_skip = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;

    // A golden length of zero means the row is checked against the predictor.
    t_dir_row dir_rows [0:N_DIR-1] = '{
        '{nff_pkg::FUNC_DEC,  32'd0,          7'd0,   1'b0, 4'd1,  "0"},
        '{nff_pkg::FUNC_DEC,  32'h7FFF_FFFF,  7'd0,   1'b0, 4'd10, "2147483647"},
        '{nff_pkg::FUNC_DEC,  32'h8000_0000,  7'd0,   1'b0, 4'd11, "-2147483648"},
        '{nff_pkg::FUNC_DEC,  32'hFFFF_FFFB,  7'd4,   1'b1, 4'd4,  "00-5"},
        '{nff_pkg::FUNC_DEC,  32'hFFFF_FFFB,  7'd4,   1'b0, 4'd4,  "  -5"},
        '{nff_pkg::FUNC_DEC,  32'd123,        7'd2,   1'b0, 4'd3,  "123"},
        '{nff_pkg::FUNC_DEC,  32'hFFFF_FFFF,  7'd0,   1'b0, 4'd2,  "-1"},
        '{nff_pkg::FUNC_DEC,  32'd1000000000, 7'd11,  1'b1, 4'd11, "01000000000"},
        '{nff_pkg::FUNC_DEC,  32'd42,         7'd64,  1'b1, 4'd0,  ""},
        '{nff_pkg::FUNC_DEC,  32'd7,          7'd127, 1'b0, 4'd0,  ""},
        '{nff_pkg::FUNC_HEX,  32'd0,          7'd0,   1'b0, 4'd1,  "0"},
        '{nff_pkg::FUNC_HEX,  32'hFFFF_FFFF,  7'd0,   1'b0, 4'd8,  "FFFFFFFF"},
        '{nff_pkg::FUNC_HEX,  32'h00AB_CDEF,  7'd8,   1'b1, 4'd8,  "00ABCDEF"},
        '{nff_pkg::FUNC_HEX,  32'h8000_0000,  7'd3,   1'b0, 4'd8,  "80000000"},
        '{nff_pkg::FUNC_HEX,  32'h1234_5678,  7'd9,   1'b0, 4'd9,  " 12345678"},
        '{nff_pkg::FUNC_HEX,  32'd1,          7'd127, 1'b1, 4'd0,  ""},
        '{nff_pkg::FUNC_CHR,  32'h0000_0041,  7'd0,   1'b0, 4'd1,  "A"},
        '{nff_pkg::FUNC_CHR,  32'h0000_007A,  7'd1,   1'b1, 4'd1,  "z"},
        '{nff_pkg::FUNC_CHR,  32'hFFFF_FF41,  7'd5,   1'b1, 4'd5,  "0000A"},
        '{nff_pkg::FUNC_CHR,  32'd0,          7'd3,   1'b0, 4'd0,  ""},
        '{nff_pkg::FUNC_CHR,  32'h0000_007E,  7'd100, 1'b0, 4'd0,  ""},
        '{nff_pkg::FUNC_NONE, 32'd12345,      7'd10,  1'b1, 4'd0,  ""},
        '{nff_pkg::FUNC_DEC,  32'd9,          7'd1,   1'b0, 4'd1,  "9"},
        '{nff_pkg::FUNC_CHR,  32'h0000_00FF,  7'd64,  1'b1, 4'd0,  ""}
    };

    number_field_formatter_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_value     (i_value),
        .i_width     (i_width),
        .i_pad_zero  (i_pad_zero),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, 6));
    endfunction

    function automatic void format_field(input logic [1:0] f, input logic [31:0] v,
                                         input logic [6:0] w, input logic pz);
        logic [7:0]  body[$];
        logic [31:0] mag;
        logic [7:0]  fill;
        int          field_w;
        fill    = pz ? nff_pkg::CH_ZERO : nff_pkg::CH_SPACE;
        field_w = (w > MAX_W) ? MAX_W : int'(w);
        case (f)
            nff_pkg::FUNC_DEC: begin
                mag = v[31] ? (~v + 32'd1) : v;
                do begin
                    body.push_front(nff_pkg::CH_ZERO + 8'(mag % 32'd10));
                    mag = mag / 32'd10;
                end while (mag != 0);
                if (v[31]) begin
                    body.push_front(nff_pkg::CH_MINUS);
                end
            end
            nff_pkg::FUNC_HEX: begin
                mag = v;
                do begin
                    body.push_front(HEX_GLYPHS[8 * (15 - int'(mag[3:0])) +: 8]);
                    mag = mag >> 4;
                end while (mag != 0);
            end
            nff_pkg::FUNC_CHR: begin
                body.push_front(v[7:0]);
            end
            default: begin
                return;
            end
        endcase
        while (body.size() < field_w) begin
            body.push_front(fill);
        end
        foreach (body[k]) begin
            pending_chars.push_back('{char_code: body[k], last: (k == body.size() - 1)});
        end
    endfunction

    function automatic void expect_golden(input logic [3:0] len, input logic [95:0] golden);
        for (int k = 0; k < len; k++) begin
            pending_chars.push_back('{char_code: golden[8 * (len - 1 - k) +: 8],
                                      last: (k == len - 1)});
        end
    endfunction

    task automatic send_word(input logic [1:0] f, input logic [31:0] v, input logic [6:0] w,
                             input logic pz, input bit hold);
        int gap;
        gap = draw_gap();
        if (gap > 0 || hold) begin
            i_in_valid <= 1'b0;
            if (hold) begin
                do @(posedge i_clk); while (pending_chars.size() != 0);
            end
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_value    <= v;
        i_width    <= w;
        i_pad_zero <= pz;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        case (f)
            nff_pkg::FUNC_DEC: n_dec++;
            nff_pkg::FUNC_HEX: n_hex++;
            nff_pkg::FUNC_CHR: n_chr++;
            default:           n_skip++;
        endcase
    endtask

    initial begin : result_checker
        int          gap;
        t_field_char want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            n_chars++;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, actual %h last %b",
                         $time, o_char_code, o_last);
                n_errors++;
            end else begin
                want = pending_chars.pop_front();
                if (o_char_code !== want.char_code) begin
                    $display("%0t: char_code mismatch: expected %h, actual %h",
                             $time, want.char_code, o_char_code);
                    n_errors++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d characters still expected",
                     $time, IDLE_LIMIT, pending_chars.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        logic [1:0]  f;
        logic [31:0] v;
        logic [6:0]  w;
        logic        pz;
        int          counted;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            send_word(dir_rows[r].func, dir_rows[r].value, dir_rows[r].width,
                      dir_rows[r].pad_zero, 1'b0);
            if (dir_rows[r].golden_len != 0) begin
                expect_golden(dir_rows[r].golden_len, dir_rows[r].golden);
            end else begin
                format_field(dir_rows[r].func, dir_rows[r].value, dir_rows[r].width,
                             dir_rows[r].pad_zero);
            end
        end

        counted = 0;
        while (counted < RANDOM_WORDS) begin
            calm = (counted >= 40 && counted < 70);
            f = ($urandom_range(0, 19) == 0) ? nff_pkg::FUNC_NONE : 2'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1: v = 32'($urandom_range(0, 2000)) - 32'd1000;
                2: begin
                    case ($urandom_range(0, 3))
                        0:       v = 32'h8000_0000;
                        1:       v = 32'h7FFF_FFFF;
                        2:       v = 32'hFFFF_FFFF;
                        default: v = 32'd0;
                    endcase
                end
                default: v = $urandom >> $urandom_range(0, 31);
            endcase
            case ($urandom_range(0, 9))
                7, 8:    w = 7'($urandom_range(13, 64));
                9:       w = 7'($urandom_range(65, 127));
                default: w = 7'($urandom_range(0, 12));
            endcase
            pz = 1'($urandom_range(0, 1));
            send_word(f, v, w, pz, counted == 100);
            format_field(f, v, w, pz);
            if (f != nff_pkg::FUNC_NONE) begin
                counted++;
            end
        end

        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d decimal, %0d hex and %0d char words plus %0d ignored words.",
                 n_dec, n_hex, n_chr, n_skip);
        $display("Checked %0d characters with %0d mismatches.", n_chars, n_errors);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/nff_pkg.sv
src/nff_digits.sv
src/nff_seq.sv
src/number_field_formatter_unit.sv
src/nff_checker.sv
dv/number_field_formatter_unit_tb.sv
